// ----- design/jcsc_pkg.sv -----
package jcsc_pkg;

  // Default fraction width of the fixed-point coefficients
  localparam int FRAC_BITS_DEF = 16;

  // Color space codes
  localparam logic [2:0] SP_GRAY = 3'd0;
  localparam logic [2:0] SP_RGB  = 3'd1;
  localparam logic [2:0] SP_YCC  = 3'd2;
  localparam logic [2:0] SP_CMYK = 3'd3;
  localparam logic [2:0] SP_YCCK = 3'd4;

  // Register indexes on the configuration port
  localparam logic REG_SOURCE = 1'b0;
  localparam logic REG_TARGET = 1'b1;

  // JFIF coefficients, five decimals, scaled by 100000
  localparam int K_YR  = 29900;
  localparam int K_YG  = 58700;
  localparam int K_YB  = 11400;
  localparam int K_CBR = 16874;
  localparam int K_CBG = 33126;
  localparam int K_HALF = 50000;
  localparam int K_CRG = 41869;
  localparam int K_CRB = 8131;
  localparam int K_RCR = 140200;
  localparam int K_GCB = 34414;
  localparam int K_GCR = 71414;
  localparam int K_BCB = 177200;

  // Selected conversion pair
  typedef struct packed {
    logic [2:0] src;
    logic [2:0] tgt;
  } cfg_t;

  // Round a five-decimal coefficient to nearest with f fraction bits
  function automatic longint fix(input int n, input int f);
    return ((longint'(n) << f) + 64'sd50000) / 64'sd100000;
  endfunction

endpackage

// ----- design/jpeg_color_space_converter.sv -----
// JPEG color space converter, one pixel per item.
// Input stream (in_*): tdata holds chan_a..chan_d, one byte each from the
// low end; tlast marks the last pixel of the image.
// Output stream (out_*): tdata holds out_a..out_d the same way, tuser is the
// unsupported flag, tlast copies the input tlast.
// Config (cfg_*, APB): source space at address 0, target space at address 4,
// codes 0 gray, 1 RGB, 2 YCbCr, 3 CMYK, 4 YCCK. Write only while no items
// are in flight; reset selects YCbCr to RGB.
// Each item passes through four register stages in order: operand prep,
// products, sums, saturate/select.
// Throughput: one item per clock while out_tready stays high.
// When the receiver stalls, the output holds its item, stages behind it keep
// filling their empty slots, and in_tready drops only once all four stages
// are occupied. Reset empties the pipe; no clearing pass is needed.
module jpeg_color_space_converter #(
  parameter int FRAC_BITS = jcsc_pkg::FRAC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,     // chan_a, chan_b, chan_c, chan_d
  input  logic        in_tlast,     // last_pixel
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,    // out_a, out_b, out_c, out_d
  output logic        out_tuser,    // unsupported
  output logic        out_tlast,    // last_out
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import jcsc_pkg::*;

  logic [2:0] src_r, tgt_r;
  logic       wr_en;
  cfg_t       cfg;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_r <= SP_YCC;
      tgt_r <= SP_RGB;
    end else if (wr_en) begin
      if (cfg_paddr[2] == REG_SOURCE) src_r <= cfg_pwdata[2:0];
      else tgt_r <= cfg_pwdata[2:0];
    end
  end

  // Register reads
  always_comb begin
    if (cfg_paddr[2] == REG_TARGET) cfg_prdata = {29'd0, tgt_r};
    else cfg_prdata = {29'd0, src_r};
  end

  assign cfg.src = src_r;
  assign cfg.tgt = tgt_r;

  jcsc_pipe #(
    .FRAC_BITS(FRAC_BITS)
  ) u_pipe (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

endmodule

// ----- design/jcsc_pipe.sv -----
module jcsc_pipe #(
  parameter int FRAC_BITS = jcsc_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  jcsc_pkg::cfg_t      cfg,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [31:0]         in_tdata,   // chan_a, chan_b, chan_c, chan_d
  input  logic                in_tlast,   // last_pixel
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [31:0]         out_tdata,  // out_a, out_b, out_c, out_d
  output logic                out_tuser,  // unsupported
  output logic                out_tlast   // last_out
);
  import jcsc_pkg::*;

  localparam int ACC_W = FRAC_BITS + 12;
  localparam int NPROD = 13;

  localparam logic signed [ACC_W-1:0] C_YR   = ACC_W'(fix(K_YR, FRAC_BITS));
  localparam logic signed [ACC_W-1:0] C_YG   = ACC_W'(fix(K_YG, FRAC_BITS));
  localparam logic signed [ACC_W-1:0] C_YB   = ACC_W'(fix(K_YB, FRAC_BITS));
  localparam logic signed [ACC_W-1:0] C_CBR  = ACC_W'(fix(K_CBR, FRAC_BITS));
  localparam logic signed [ACC_W-1:0] C_CBG  = ACC_W'(fix(K_CBG, FRAC_BITS));
  localparam logic signed [ACC_W-1:0] C_HALF = ACC_W'(fix(K_HALF, FRAC_BITS));
  localparam logic signed [ACC_W-1:0] C_CRG  = ACC_W'(fix(K_CRG, FRAC_BITS));
  localparam logic signed [ACC_W-1:0] C_CRB  = ACC_W'(fix(K_CRB, FRAC_BITS));
  localparam logic signed [ACC_W-1:0] C_RCR  = ACC_W'(fix(K_RCR, FRAC_BITS));
  localparam logic signed [ACC_W-1:0] C_GCB  = ACC_W'(fix(K_GCB, FRAC_BITS));
  localparam logic signed [ACC_W-1:0] C_GCR  = ACC_W'(fix(K_GCR, FRAC_BITS));
  localparam logic signed [ACC_W-1:0] C_BCB  = ACC_W'(fix(K_BCB, FRAC_BITS));
  localparam logic signed [ACC_W-1:0] C_OFS  = ACC_W'(longint'(128) << FRAC_BITS);
  localparam logic signed [ACC_W-1:0] C_FULL = ACC_W'(longint'(255) << FRAC_BITS);

  typedef enum logic [3:0] {
    MD_PASS,
    MD_G2RGB,
    MD_G2YCC,
    MD_RGB2G,
    MD_RGB2YCC,
    MD_YCC2G,
    MD_YCC2RGB,
    MD_CMYK2YCCK,
    MD_YCCK2CMYK,
    MD_BAD
  } mode_t;

  // Control and raw pixel that travel alongside the arithmetic
  typedef struct packed {
    mode_t       md;
    logic [2:0]  src;
    logic [31:0] pix;
    logic        last;
  } side_t;

  function automatic logic signed [ACC_W-1:0] mul(input logic signed [ACC_W-1:0] x,
                                                  input logic signed [ACC_W-1:0] y);
    return x * y;
  endfunction

  // Floor to integer, clamp to 0..255
  function automatic logic [7:0] sat8(input logic signed [ACC_W-1:0] v);
    logic [7:0] res;
    if (v[ACC_W-1]) res = 8'd0;
    else if (|v[ACC_W-2:FRAC_BITS+8]) res = 8'd255;
    else res = v[FRAC_BITS+7:FRAC_BITS];
    return res;
  endfunction

  // Handshake: each stage moves when it is empty or the next one moves
  logic v0_r, v1_r, v2_r, v3_r;
  logic en0, en1, en2, en3;

  assign en3 = !v3_r || out_tready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign en0 = !v0_r || en1;
  assign in_tready = en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_tvalid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // Stage 0: decode the pair and prepare operands
  mode_t       md_nxt;
  logic [8:0]  fr_nxt, fg_nxt, fb_nxt;
  side_t       sd0_r, sd1_r, sd2_r, sd3_r;
  logic [8:0]  fr0_r, fg0_r, fb0_r;
  logic [7:0]  iy0_r;
  logic signed [8:0] icb0_r, icr0_r;

  always_comb begin
    if (!(cfg.src inside {[SP_GRAY:SP_YCCK]}) || !(cfg.tgt inside {[SP_GRAY:SP_YCCK]}))
      md_nxt = MD_BAD;
    else if (cfg.src == cfg.tgt) md_nxt = MD_PASS;
    else if (cfg.src == SP_GRAY && cfg.tgt == SP_RGB)  md_nxt = MD_G2RGB;
    else if (cfg.src == SP_GRAY && cfg.tgt == SP_YCC)  md_nxt = MD_G2YCC;
    else if (cfg.src == SP_RGB  && cfg.tgt == SP_GRAY) md_nxt = MD_RGB2G;
    else if (cfg.src == SP_RGB  && cfg.tgt == SP_YCC)  md_nxt = MD_RGB2YCC;
    else if (cfg.src == SP_YCC  && cfg.tgt == SP_GRAY) md_nxt = MD_YCC2G;
    else if (cfg.src == SP_YCC  && cfg.tgt == SP_RGB)  md_nxt = MD_YCC2RGB;
    else if (cfg.src == SP_CMYK && cfg.tgt == SP_YCCK) md_nxt = MD_CMYK2YCCK;
    else if (cfg.src == SP_YCCK && cfg.tgt == SP_CMYK) md_nxt = MD_YCCK2CMYK;
    else md_nxt = MD_BAD;
  end

  // CMYK input is inverted to RGB before the forward transform
  always_comb begin
    if (md_nxt == MD_CMYK2YCCK) begin
      fr_nxt = 9'd255 - {1'b0, in_tdata[7:0]};
      fg_nxt = 9'd255 - {1'b0, in_tdata[15:8]};
      fb_nxt = 9'd255 - {1'b0, in_tdata[23:16]};
    end else begin
      fr_nxt = {1'b0, in_tdata[7:0]};
      fg_nxt = {1'b0, in_tdata[15:8]};
      fb_nxt = {1'b0, in_tdata[23:16]};
    end
  end

  always_ff @(posedge clk) begin
    if (en0 && in_tvalid) begin
      sd0_r.md   <= md_nxt;
      sd0_r.src  <= cfg.src;
      sd0_r.pix  <= in_tdata;
      sd0_r.last <= in_tlast;
      fr0_r      <= fr_nxt;
      fg0_r      <= fg_nxt;
      fb0_r      <= fb_nxt;
      iy0_r      <= in_tdata[7:0];
      icb0_r     <= $signed({1'b0, in_tdata[15:8]}) - 9'sd128;
      icr0_r     <= $signed({1'b0, in_tdata[23:16]}) - 9'sd128;
    end
  end

  // Stage 1: all coefficient products
  logic signed [ACC_W-1:0] opr, opg, opb, opcb, opcr;
  logic signed [ACC_W-1:0] prod_nxt [NPROD];
  logic signed [ACC_W-1:0] prod1_r [NPROD];
  logic signed [ACC_W-1:0] yf1_r;

  assign opr  = {{(ACC_W-9){1'b0}}, fr0_r};
  assign opg  = {{(ACC_W-9){1'b0}}, fg0_r};
  assign opb  = {{(ACC_W-9){1'b0}}, fb0_r};
  assign opcb = {{(ACC_W-9){icb0_r[8]}}, icb0_r};
  assign opcr = {{(ACC_W-9){icr0_r[8]}}, icr0_r};

  always_comb begin
    prod_nxt[0]  = mul(C_YR, opr);
    prod_nxt[1]  = mul(C_YG, opg);
    prod_nxt[2]  = mul(C_YB, opb);
    prod_nxt[3]  = mul(C_CBR, opr);
    prod_nxt[4]  = mul(C_CBG, opg);
    prod_nxt[5]  = mul(C_HALF, opb);
    prod_nxt[6]  = mul(C_HALF, opr);
    prod_nxt[7]  = mul(C_CRG, opg);
    prod_nxt[8]  = mul(C_CRB, opb);
    prod_nxt[9]  = mul(C_RCR, opcr);
    prod_nxt[10] = mul(C_GCB, opcb);
    prod_nxt[11] = mul(C_GCR, opcr);
    prod_nxt[12] = mul(C_BCB, opcb);
  end

  always_ff @(posedge clk) begin
    if (en1 && v0_r) begin
      sd1_r   <= sd0_r;
      prod1_r <= prod_nxt;
      yf1_r   <= {{(ACC_W-8){1'b0}}, iy0_r} <<< FRAC_BITS;
    end
  end

  // Stage 2: sums of products
  logic signed [ACC_W-1:0] y2_r, cb2_r, cr2_r, r2_r, g2_r, b2_r;

  always_ff @(posedge clk) begin
    if (en2 && v1_r) begin
      sd2_r <= sd1_r;
      y2_r  <= prod1_r[0] + prod1_r[1] + prod1_r[2];
      cb2_r <= prod1_r[5] - prod1_r[3] - prod1_r[4] + C_OFS;
      cr2_r <= prod1_r[6] - prod1_r[7] - prod1_r[8] + C_OFS;
      r2_r  <= yf1_r + prod1_r[9];
      g2_r  <= yf1_r - prod1_r[10] - prod1_r[11];
      b2_r  <= yf1_r + prod1_r[12];
    end
  end

  // Stage 3: saturate and pick the output channels
  logic [7:0] qa, qb, qc, qd, pa, pb, pc, pd;
  logic       bad_nxt;
  logic [31:0] odata_r;
  logic        obad_r, olast_r;

  assign pa = sd2_r.pix[7:0];
  assign pb = sd2_r.pix[15:8];
  assign pc = sd2_r.pix[23:16];
  assign pd = sd2_r.pix[31:24];

  always_comb begin
    qa = 8'd0;
    qb = 8'd0;
    qc = 8'd0;
    qd = 8'd0;
    bad_nxt = 1'b0;
    case (sd2_r.md)
      MD_PASS: begin
        qa = pa;
        if (sd2_r.src != SP_GRAY) begin
          qb = pb;
          qc = pc;
        end
        if (sd2_r.src == SP_RGB) qd = 8'd255;
        else if (sd2_r.src inside {SP_CMYK, SP_YCCK}) qd = pd;
      end
      MD_G2RGB: begin
        qa = pa;
        qb = pa;
        qc = pa;
        qd = 8'd255;
      end
      MD_G2YCC: begin
        qa = pa;
        qb = 8'd128;
        qc = 8'd128;
      end
      MD_RGB2G: qa = sat8(y2_r);
      MD_RGB2YCC: begin
        qa = sat8(y2_r);
        qb = sat8(cb2_r);
        qc = sat8(cr2_r);
      end
      MD_YCC2G: qa = pa;
      MD_YCC2RGB: begin
        qa = sat8(r2_r);
        qb = sat8(g2_r);
        qc = sat8(b2_r);
        qd = 8'd255;
      end
      MD_CMYK2YCCK: begin
        qa = sat8(y2_r);
        qb = sat8(cb2_r);
        qc = sat8(cr2_r);
        qd = pd;
      end
      MD_YCCK2CMYK: begin
        qa = sat8(C_FULL - r2_r);
        qb = sat8(C_FULL - g2_r);
        qc = sat8(C_FULL - b2_r);
        qd = pd;
      end
      default: bad_nxt = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      sd3_r   <= sd2_r;
      odata_r <= {qd, qc, qb, qa};
      obad_r  <= bad_nxt;
      olast_r <= sd2_r.last;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = obad_r;
  assign out_tlast  = olast_r;

  // An unsupported pair carries all-zero channels
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata == 32'd0)
    else $error("unsupported item with nonzero channels");

  // Input backpressure only comes from a full pipe stalled at the output
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> v0_r && v1_r && v2_r && out_tvalid && !out_tready)
    else $error("input stalled while pipe has room");

  // An item in stage 2 reaches the output register when it may move
  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && en3 |=> v3_r)
    else $error("item lost between stage 2 and output");

  // A YCbCr to RGB result always carries full alpha
  a_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    v3_r && sd3_r.md == MD_YCC2RGB |-> out_tdata[31:24] == 8'd255)
    else $error("RGB output without full alpha");

  // Reset empties the pipe
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

// ----- bench/tb_jpeg_color_space_converter.sv -----
module tb_jpeg_color_space_converter;
  import jcsc_pkg::*;

  localparam int FB = FRAC_BITS_DEF;
  localparam int PIPE_DEPTH = 4;
  localparam int CYCLE_LIMIT = 500000;
  localparam int PHASES = 14;
  localparam int PHASE_ITEMS = 100;

  // Register codes with no color space behind them
  localparam logic [2:0] SP_BAD_LO = 3'd5;
  localparam logic [2:0] SP_BAD_HI = 3'd7;

  // Round a five-decimal coefficient to the block's fixed point
  function automatic longint q_round(input longint scaled);
    return ((scaled <<< FB) + 64'sd50000) / 64'sd100000;
  endfunction

  localparam longint C_YR   = q_round(29900);
  localparam longint C_YG   = q_round(58700);
  localparam longint C_YB   = q_round(11400);
  localparam longint C_CBR  = q_round(16874);
  localparam longint C_CBG  = q_round(33126);
  localparam longint C_HALF = q_round(50000);
  localparam longint C_CRG  = q_round(41869);
  localparam longint C_CRB  = q_round(8131);
  localparam longint C_RCR  = q_round(140200);
  localparam longint C_GCB  = q_round(34414);
  localparam longint C_GCR  = q_round(71414);
  localparam longint C_BCB  = q_round(177200);
  localparam longint OFS128 = longint'(128) <<< FB;
  localparam longint FULL255 = longint'(255) <<< FB;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
    logic       last;
  } pixel_t;

  typedef struct packed {
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] c;
    logic [7:0] d;
    logic       bad;
    logic       last;
  } color_out_t;

  typedef struct packed {
    logic [2:0] src;
    logic [2:0] tgt;
    pixel_t     px;
    logic       typed;
    color_out_t want;
  } dir_row_t;

  localparam color_out_t NONE = '0;

  // Directed pixels; rows with typed set carry their result directly
  localparam int DIR_ROWS = 26;
  localparam dir_row_t DIRECTED [DIR_ROWS] = '{
    // reset selection: YCbCr to RGB, mid-chroma black
    '{SP_YCC,  SP_RGB,  '{8'd0,   8'd128, 8'd128, 8'd0,   1'b0}, 1'b1,
      '{8'd0,   8'd0,   8'd0,   8'd255, 1'b0, 1'b0}},
    '{SP_YCC,  SP_RGB,  '{8'd255, 8'd0,   8'd255, 8'd9,   1'b0}, 1'b0, NONE},
    '{SP_YCC,  SP_RGB,  '{8'd0,   8'd255, 8'd0,   8'd255, 1'b1}, 1'b0, NONE},
    '{SP_GRAY, SP_RGB,  '{8'd200, 8'd1,   8'd2,   8'd3,   1'b0}, 1'b1,
      '{8'd200, 8'd200, 8'd200, 8'd255, 1'b0, 1'b0}},
    '{SP_GRAY, SP_YCC,  '{8'd37,  8'd255, 8'd255, 8'd255, 1'b1}, 1'b1,
      '{8'd37,  8'd128, 8'd128, 8'd0,   1'b0, 1'b1}},
    '{SP_RGB,  SP_GRAY, '{8'd255, 8'd255, 8'd255, 8'd0,   1'b0}, 1'b0, NONE},
    '{SP_RGB,  SP_GRAY, '{8'd0,   8'd0,   8'd0,   8'd255, 1'b0}, 1'b1,
      '{8'd0,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0}},
    '{SP_RGB,  SP_YCC,  '{8'd255, 8'd0,   8'd0,   8'd0,   1'b0}, 1'b0, NONE},
    '{SP_RGB,  SP_YCC,  '{8'd0,   8'd0,   8'd255, 8'd0,   1'b0}, 1'b0, NONE},
    '{SP_RGB,  SP_YCC,  '{8'd0,   8'd255, 8'd0,   8'd0,   1'b1}, 1'b0, NONE},
    '{SP_YCC,  SP_GRAY, '{8'd99,  8'd0,   8'd255, 8'd7,   1'b0}, 1'b1,
      '{8'd99,  8'd0,   8'd0,   8'd0,   1'b0, 1'b0}},
    '{SP_CMYK, SP_YCCK, '{8'd0,   8'd0,   8'd0,   8'd77,  1'b0}, 1'b0, NONE},
    '{SP_CMYK, SP_YCCK, '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0}, 1'b0, NONE},
    '{SP_YCCK, SP_CMYK, '{8'd255, 8'd0,   8'd255, 8'd12,  1'b0}, 1'b0, NONE},
    '{SP_YCCK, SP_CMYK, '{8'd0,   8'd255, 8'd0,   8'd200, 1'b1}, 1'b0, NONE},
    // same space on both sides
    '{SP_GRAY, SP_GRAY, '{8'd5,   8'd6,   8'd7,   8'd8,   1'b0}, 1'b1,
      '{8'd5,   8'd0,   8'd0,   8'd0,   1'b0, 1'b0}},
    '{SP_RGB,  SP_RGB,  '{8'd10,  8'd20,  8'd30,  8'd40,  1'b0}, 1'b1,
      '{8'd10,  8'd20,  8'd30,  8'd255, 1'b0, 1'b0}},
    '{SP_YCC,  SP_YCC,  '{8'd1,   8'd2,   8'd3,   8'd4,   1'b0}, 1'b1,
      '{8'd1,   8'd2,   8'd3,   8'd0,   1'b0, 1'b0}},
    '{SP_CMYK, SP_CMYK, '{8'd11,  8'd22,  8'd33,  8'd44,  1'b0}, 1'b1,
      '{8'd11,  8'd22,  8'd33,  8'd44,  1'b0, 1'b0}},
    '{SP_YCCK, SP_YCCK, '{8'd255, 8'd128, 8'd0,   8'd255, 1'b1}, 1'b1,
      '{8'd255, 8'd128, 8'd0,   8'd255, 1'b0, 1'b1}},
    // pairs with no conversion, and codes past YCCK
    '{SP_GRAY, SP_CMYK, '{8'd50,  8'd60,  8'd70,  8'd80,  1'b0}, 1'b1,
      '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b0}},
    '{SP_CMYK, SP_RGB,  '{8'd255, 8'd255, 8'd255, 8'd255, 1'b0}, 1'b1,
      '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b0}},
    '{SP_YCCK, SP_YCC,  '{8'd90,  8'd91,  8'd92,  8'd93,  1'b1}, 1'b1,
      '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b1}},
    '{SP_BAD_LO, SP_RGB, '{8'd128, 8'd128, 8'd128, 8'd128, 1'b0}, 1'b1,
      '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b0}},
    '{SP_RGB,  SP_BAD_HI, '{8'd1,  8'd254, 8'd127, 8'd3,  1'b1}, 1'b1,
      '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b1}},
    '{SP_BAD_HI, SP_BAD_HI, '{8'd255, 8'd0, 8'd0,  8'd255, 1'b0}, 1'b1,
      '{8'd0,   8'd0,   8'd0,   8'd0,   1'b1, 1'b0}}
  };

  // Space pairs that have a conversion, identities included
  localparam int PAIRS = 13;
  localparam logic [2:0] PAIR_SRC [PAIRS] = '{SP_GRAY, SP_GRAY, SP_RGB, SP_RGB, SP_YCC,
    SP_YCC, SP_CMYK, SP_YCCK, SP_GRAY, SP_RGB, SP_YCC, SP_CMYK, SP_YCCK};
  localparam logic [2:0] PAIR_TGT [PAIRS] = '{SP_RGB, SP_YCC, SP_GRAY, SP_YCC, SP_GRAY,
    SP_RGB, SP_YCCK, SP_CMYK, SP_GRAY, SP_RGB, SP_YCC, SP_CMYK, SP_YCCK};

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;     // chan_a, chan_b, chan_c, chan_d
  logic        in_tlast;     // last_pixel
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;    // out_a, out_b, out_c, out_d
  logic        out_tuser;    // unsupported
  logic        out_tlast;    // last_out
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [2:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  jpeg_color_space_converter dut (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Mirror of the space registers and the results still owed
  logic [2:0] cur_src;
  logic [2:0] cur_tgt;
  color_out_t pending_colors [$];
  int         error_count = 0;
  int         cycle_count = 0;
  int         sink_hold = 0;
  bit         steady = 1'b0;

  // Saturate a fixed-point value to a byte, flooring the fraction
  function automatic logic [7:0] clamp_byte(input longint v);
    longint w;
    if (v < 0) return 8'd0;
    w = v >>> FB;
    if (w > 255) return 8'd255;
    return w[7:0];
  endfunction

  function automatic void rgb_ycc(input longint r, g, b, output logic [7:0] y, cb, cr);
    y  = clamp_byte(C_YR * r + C_YG * g + C_YB * b);
    cb = clamp_byte(-C_CBR * r - C_CBG * g + C_HALF * b + OFS128);
    cr = clamp_byte(C_HALF * r - C_CRG * g - C_CRB * b + OFS128);
  endfunction

  // Unsaturated fixed-point R, G, B
  function automatic void ycc_fixed(input longint y, cb, cr, output longint r, g, b);
    longint yf;
    yf = y <<< FB;
    r = yf + C_RCR * (cr - 128);
    g = yf - C_GCB * (cb - 128) - C_GCR * (cr - 128);
    b = yf + C_BCB * (cb - 128);
  endfunction

  function automatic color_out_t convert_pixel(input logic [2:0] s, t, input pixel_t px);
    color_out_t o;
    longint a, b, c, r, g, bl;
    o = '0;
    o.last = px.last;
    a = px.a;
    b = px.b;
    c = px.c;
    if (s > SP_YCCK || t > SP_YCCK) begin
      o.bad = 1'b1;
    end else if (s == t) begin
      o.a = px.a;
      if (s != SP_GRAY) begin
        o.b = px.b;
        o.c = px.c;
      end
      if (s == SP_RGB) o.d = 8'd255;
      else if (s == SP_CMYK || s == SP_YCCK) o.d = px.d;
    end else if (s == SP_GRAY && t == SP_RGB) begin
      o.a = px.a;
      o.b = px.a;
      o.c = px.a;
      o.d = 8'd255;
    end else if (s == SP_GRAY && t == SP_YCC) begin
      o.a = px.a;
      o.b = 8'd128;
      o.c = 8'd128;
    end else if (s == SP_RGB && t == SP_GRAY) begin
      o.a = clamp_byte(C_YR * a + C_YG * b + C_YB * c);
    end else if (s == SP_RGB && t == SP_YCC) begin
      rgb_ycc(a, b, c, o.a, o.b, o.c);
    end else if (s == SP_YCC && t == SP_GRAY) begin
      o.a = px.a;
    end else if (s == SP_YCC && t == SP_RGB) begin
      ycc_fixed(a, b, c, r, g, bl);
      o.a = clamp_byte(r);
      o.b = clamp_byte(g);
      o.c = clamp_byte(bl);
      o.d = 8'd255;
    end else if (s == SP_CMYK && t == SP_YCCK) begin
      rgb_ycc(255 - a, 255 - b, 255 - c, o.a, o.b, o.c);
      o.d = px.d;
    end else if (s == SP_YCCK && t == SP_CMYK) begin
      ycc_fixed(a, b, c, r, g, bl);
      o.a = clamp_byte(FULL255 - r);
      o.b = clamp_byte(FULL255 - g);
      o.c = clamp_byte(FULL255 - bl);
      o.d = px.d;
    end else begin
      o.bad = 1'b1;
    end
    return o;
  endfunction

  function automatic int pick_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom());
    endcase
  endfunction

  // APB write: setup cycle, then access until pready
  task automatic write_reg(input logic idx, input logic [2:0] code);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= {29'($urandom()), code};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Hold off until every owed result is back, plus a margin set by PIPE_DEPTH
  task automatic wait_drained();
    while (pending_colors.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 2) @(posedge clk);
  endtask

  // Input goes idle before the pipe drains and the spaces change
  task automatic select_spaces(input logic [2:0] s, t);
    in_tvalid <= 1'b0;
    wait_drained();
    write_reg(REG_SOURCE, s);
    write_reg(REG_TARGET, t);
    cur_src = s;
    cur_tgt = t;
  endtask

  // Present one pixel, wait for the handshake, then queue its result
  task automatic send_pixel(input pixel_t px, input logic typed, input color_out_t want);
    color_out_t exp_c;
    in_tvalid <= 1'b1;
    in_tdata <= {px.d, px.c, px.b, px.a};
    in_tlast <= px.last;
    do @(posedge clk); while (!in_tready);
    exp_c = typed ? want : convert_pixel(cur_src, cur_tgt, px);
    pending_colors.push_back(exp_c);
  endtask

  // Optional gap after an item; lowers valid only when needed
  task automatic after_item(input bit phase_end);
    int gap;
    gap = phase_end ? 0 : pick_gap();
    if (phase_end || gap > 0) in_tvalid <= 1'b0;
    repeat (gap) @(posedge clk);
  endtask

  // Receiver back-pressure
  always @(posedge clk) begin
    int r;
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      out_tready <= 1'b0;
    end else if (steady) begin
      out_tready <= 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= 1'b0;
        sink_hold <= (r < 95) ? $urandom_range(0, 2) : $urandom_range(8, 30);
      end
    end
  end

  task automatic report(input string field, input int exp_v, input int act_v);
    $error("%s mismatch: expected %0d, got %0d", field, exp_v, act_v);
    error_count++;
  endtask

  // Result checker
  always @(posedge clk) begin
    color_out_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_colors.size() == 0) begin
        $error("result item with nothing expected: tdata %h", out_tdata);
        error_count++;
      end else begin
        e = pending_colors.pop_front();
        if (out_tdata[7:0] !== e.a)
          report("out_a", int'(e.a), int'(out_tdata[7:0]));
        if (out_tdata[15:8] !== e.b)
          report("out_b", int'(e.b), int'(out_tdata[15:8]));
        if (out_tdata[23:16] !== e.c)
          report("out_c", int'(e.c), int'(out_tdata[23:16]));
        if (out_tdata[31:24] !== e.d)
          report("out_d", int'(e.d), int'(out_tdata[31:24]));
        if (out_tuser !== e.bad)
          report("unsupported", int'(e.bad), int'(out_tuser));
        if (out_tlast !== e.last)
          report("last_out", int'(e.last), int'(out_tlast));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    pixel_t px;
    int k;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tlast <= 1'b0;
    out_tready <= 1'b0;
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= '0;
    cfg_pwdata <= '0;
    cur_src = SP_YCC;
    cur_tgt = SP_RGB;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table; first rows run on the reset selection
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIRECTED[i].src != cur_src || DIRECTED[i].tgt != cur_tgt)
        select_spaces(DIRECTED[i].src, DIRECTED[i].tgt);
      send_pixel(DIRECTED[i].px, DIRECTED[i].typed, DIRECTED[i].want);
      after_item(i == DIR_ROWS - 1);
    end

    // Random phases, each on its own space pair; every fifth runs flat out
    for (int ph = 0; ph < PHASES; ph++) begin
      if ($urandom_range(0, 9) < 7) begin
        k = $urandom_range(0, PAIRS - 1);
        select_spaces(PAIR_SRC[k], PAIR_TGT[k]);
      end else begin
        select_spaces(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
      end
      steady = (ph % 5 == 0);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        px.a = pick_byte();
        px.b = pick_byte();
        px.c = pick_byte();
        px.d = pick_byte();
        px.last = ($urandom_range(0, 11) == 0);
        send_pixel(px, 1'b0, NONE);
        after_item(n == PHASE_ITEMS - 1);
      end
    end

    steady = 1'b0;
    wait_drained();
    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ----- jpeg_color_space_converter.f -----
design/jcsc_pkg.sv
design/jcsc_pipe.sv
design/jpeg_color_space_converter.sv
bench/tb_jpeg_color_space_converter.sv
